// ----- src/pmst_pkg.sv -----
// shared constants, register codes and item flag type for the moving sum trigger
`default_nettype none

package pmst_pkg;

    localparam int PIX_W      = 16;
    localparam int SUM_W      = 20;
    localparam int TOT_W      = 24;
    localparam int PAIRS_W    = 11;
    localparam int THR_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PAIRS_IN_USE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_THRESHOLD = 1'b1;

    localparam logic [PAIRS_W-1:0] PAIRS_RESET = 11'd1024;
    localparam logic [THR_W-1:0]   THR_RESET   = 20'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic last_pair;
        logic last_frame;
    } item_flags_t;

endpackage

`default_nettype wire

// ----- src/pmst_front.sv -----
// front end: accepts pixel beats and tags each with its pair, slot and frame flags
`default_nettype none

module pmst_front #(
    parameter int MAX_PAIRS     = 1024,
    parameter int WINDOW_FRAMES = 4,
    parameter int BATCH_FRAMES  = 128,
    parameter int PAIR_W        = 10,
    parameter int SLOT_W        = 2,
    parameter int FRAME_W       = 7
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [pmst_pkg::PAIRS_W-1:0]      pairs_in_use,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output logic [PAIR_W-1:0]                      item_pair,
    output logic [SLOT_W-1:0]                      item_slot,
    output pmst_pkg::item_flags_t                  item_flags
);

    localparam int NW = pmst_pkg::PAIRS_W + 1;

    logic [PAIR_W-1:0]  pair_reg, pair_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [NW-1:0]      n_act;
    logic               last_pair, last_frame;

    // clamp the configured pair count into 1..MAX_PAIRS
    always_comb
    begin
        if (pairs_in_use == '0)
            n_act = NW'(1);
        else if ({1'b0, pairs_in_use} > NW'(MAX_PAIRS))
            n_act = NW'(MAX_PAIRS);
        else
            n_act = {1'b0, pairs_in_use};
    end

    assign last_pair  = (NW'(pair_reg) + NW'(1)) >= n_act;
    assign last_frame = frame_reg == FRAME_W'(BATCH_FRAMES - 1);

    assign in_ready   = !q_full;
    assign q_push     = in_valid && in_ready;
    assign item_pair  = pair_reg;
    assign item_slot  = slot_reg;
    assign item_flags = '{last_pair: last_pair, last_frame: last_frame};

    always_comb
    begin
        pair_next  = pair_reg;
        slot_next  = slot_reg;
        frame_next = frame_reg;
        if (q_push)
        begin
            if (last_pair)
            begin
                pair_next = '0;
                if (last_frame)
                begin
                    frame_next = '0;
                    slot_next  = '0;
                end
                else
                begin
                    frame_next = frame_reg + FRAME_W'(1);
                    slot_next  = (slot_reg == SLOT_W'(WINDOW_FRAMES - 1)) ?
                                 '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                pair_next = pair_reg + PAIR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg  <= '0;
            slot_reg  <= '0;
            frame_reg <= '0;
        end
        else
        begin
            pair_reg  <= pair_next;
            slot_reg  <= slot_next;
            frame_reg <= frame_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pmst_queue.sv -----
// short first-word-fall-through queue between front and back end
`default_nettype none

module pmst_queue #(
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic [DW-1:0]      pop_data,
    output logic               not_empty
);

    localparam int PW = pmst_pkg::QUEUE_PTR_W;

    logic [DW-1:0] entry_reg [pmst_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full      = cnt_reg == (PW+1)'(pmst_pkg::QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + (PW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (PW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- src/pmst_back.sv -----
// back end: per-pair row memory read-modify-write, trigger decision and output register
`default_nettype none

module pmst_back #(
    parameter int MAX_PAIRS     = 1024,
    parameter int WINDOW_FRAMES = 4,
    parameter int PAIR_W        = 10,
    parameter int SLOT_W        = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire logic [PAIR_W-1:0]              q_pair,
    input  wire logic [SLOT_W-1:0]              q_slot,
    input  wire pmst_pkg::item_flags_t          q_flags,
    input  wire logic [pmst_pkg::PIX_W-1:0]     q_lo,
    input  wire logic [pmst_pkg::PIX_W-1:0]     q_hi,
    output logic                                q_pop,
    input  wire logic [pmst_pkg::THR_W-1:0]     window_threshold,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                trigger_pulse,
    output logic                                totals_valid,
    output logic [pmst_pkg::TOT_W-1:0]          total_low,
    output logic [pmst_pkg::TOT_W-1:0]          total_high,
    output logic                                batch_end
);

    localparam int PIX_W  = pmst_pkg::PIX_W;
    localparam int SUM_W  = pmst_pkg::SUM_W;
    localparam int TOT_W  = pmst_pkg::TOT_W;
    localparam int WORD_W = 2 * PIX_W;
    localparam int WIN_W  = WINDOW_FRAMES * WORD_W;
    localparam int ROW_W  = WIN_W + 2 * SUM_W + 2 * TOT_W;

    // one row per pair: window words, then window sums, then batch totals
    logic [ROW_W-1:0] row_mem [MAX_PAIRS];
    logic [ROW_W-1:0] rd_row_reg;

    logic                  s1_v_reg, s1_v_next;
    logic [PAIR_W-1:0]     s1_pair_reg;
    logic [SLOT_W-1:0]     s1_slot_reg;
    pmst_pkg::item_flags_t s1_flags_reg;
    logic [PIX_W-1:0]      s1_lo_reg, s1_hi_reg;

    logic                  out_v_reg, out_v_next;
    logic                  pulse_reg;
    logic                  tv_reg;
    logic [TOT_W-1:0]      tl_reg, th_reg;
    logic                  be_reg;

    logic                  trig_reg, trig_next;
    logic                  clr_active_reg, clr_active_next;
    logic [PAIR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                  byp_v_reg, byp_v_next;
    logic [PAIR_W-1:0]     byp_pair_reg;
    logic [ROW_W-1:0]      byp_row_reg;

    logic                  fire, batch_item, hit, pulse;
    logic [ROW_W-1:0]      row_cur, row_new;
    logic [WORD_W-1:0]     old_word;
    logic [SUM_W-1:0]      ws_lo, ws_hi, wl_new, wh_new;
    logic [TOT_W-1:0]      to_lo, to_hi, tl_new, th_new;
    logic                  mem_we;
    logic [PAIR_W-1:0]     mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    assign fire       = s1_v_reg && (!out_v_reg || out_ready);
    assign batch_item = s1_flags_reg.last_pair && s1_flags_reg.last_frame;
    // hold issue while a batch-closing beat waits and during the clearing sweep
    assign q_pop      = q_valid && !clr_active_reg && !(s1_v_reg && batch_item)
                        && (!s1_v_reg || fire);

    // previous write may have landed after this row was read
    assign row_cur = (byp_v_reg && byp_pair_reg == s1_pair_reg) ? byp_row_reg : rd_row_reg;

    assign ws_lo = row_cur[WIN_W +: SUM_W];
    assign ws_hi = row_cur[WIN_W + SUM_W +: SUM_W];
    assign to_lo = row_cur[WIN_W + 2 * SUM_W +: TOT_W];
    assign to_hi = row_cur[WIN_W + 2 * SUM_W + TOT_W +: TOT_W];

    always_comb
    begin
        old_word = '0;
        for (int i = 0; i < WINDOW_FRAMES; i++)
        begin
            if (SLOT_W'(i) == s1_slot_reg)
                old_word = row_cur[i * WORD_W +: WORD_W];
        end
    end

    assign wl_new = ws_lo - SUM_W'(old_word[PIX_W-1:0]) + SUM_W'(s1_lo_reg);
    assign wh_new = ws_hi - SUM_W'(old_word[WORD_W-1:PIX_W]) + SUM_W'(s1_hi_reg);
    assign tl_new = to_lo + TOT_W'(s1_lo_reg);
    assign th_new = to_hi + TOT_W'(s1_hi_reg);
    assign hit    = (wl_new > window_threshold) || (wh_new > window_threshold);
    assign pulse  = hit && !trig_reg;

    always_comb
    begin
        row_new = row_cur;
        for (int i = 0; i < WINDOW_FRAMES; i++)
        begin
            if (SLOT_W'(i) == s1_slot_reg)
                row_new[i * WORD_W +: WORD_W] = {s1_hi_reg, s1_lo_reg};
        end
        row_new[WIN_W +: SUM_W]                     = wl_new;
        row_new[WIN_W + SUM_W +: SUM_W]             = wh_new;
        row_new[WIN_W + 2 * SUM_W +: TOT_W]         = tl_new;
        row_new[WIN_W + 2 * SUM_W + TOT_W +: TOT_W] = th_new;
    end

    assign mem_we    = fire || clr_active_reg;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : s1_pair_reg;
    assign mem_wdata = clr_active_reg ? '0 : row_new;

    always_comb
    begin
        s1_v_next       = q_pop ? 1'b1 : (fire ? 1'b0 : s1_v_reg);
        out_v_next      = fire ? 1'b1 : ((out_v_reg && out_ready) ? 1'b0 : out_v_reg);
        trig_next       = trig_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        byp_v_next      = byp_v_reg;
        if (fire)
        begin
            trig_next  = s1_flags_reg.last_pair ? 1'b0 : (trig_reg || hit);
            byp_v_next = !batch_item;
            if (batch_item)
            begin
                clr_active_next = 1'b1;
                clr_addr_next   = '0;
            end
        end
        else if (clr_active_reg)
        begin
            byp_v_next = 1'b0;
            if (clr_addr_reg == PAIR_W'(MAX_PAIRS - 1))
            begin
                clr_active_next = 1'b0;
                clr_addr_next   = '0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + PAIR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            trig_reg       <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            byp_v_reg      <= 1'b0;
        end
        else
        begin
            s1_v_reg       <= s1_v_next;
            out_v_reg      <= out_v_next;
            trig_reg       <= trig_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            byp_v_reg      <= byp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_pair_reg  <= q_pair;
            s1_slot_reg  <= q_slot;
            s1_flags_reg <= q_flags;
            s1_lo_reg    <= q_lo;
            s1_hi_reg    <= q_hi;
        end
        if (fire)
        begin
            pulse_reg    <= pulse;
            tv_reg       <= s1_flags_reg.last_frame;
            tl_reg       <= s1_flags_reg.last_frame ? tl_new : '0;
            th_reg       <= s1_flags_reg.last_frame ? th_new : '0;
            be_reg       <= batch_item;
            byp_pair_reg <= s1_pair_reg;
            byp_row_reg  <= row_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_waddr] <= mem_wdata;
        if (q_pop)
            rd_row_reg <= row_mem[q_pair];
    end

    assign out_valid     = out_v_reg;
    assign trigger_pulse = pulse_reg;
    assign totals_valid  = tv_reg;
    assign total_low     = tl_reg;
    assign total_high    = th_reg;
    assign batch_end     = be_reg;

`ifndef SYNTH
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_active_reg && fire))
        else $error("compute write during clearing sweep");

    a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !q_pop)
        else $error("row read issued during clearing sweep");

    a_clear_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && batch_item) |=> (clr_active_reg && clr_addr_reg == '0))
        else $error("clearing sweep did not follow batch close");

    a_no_bypass_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !byp_v_reg)
        else $error("bypass row live across clearing sweep");
`endif

endmodule

`default_nettype wire

// ----- src/pixel_moving_sum_trigger_top.sv -----
// top level of the moving window sum trigger: config registers, front, queue and back end
// an accepted beat passes through the queue, the stage-1 registers and the result registers
// throughput: one beat per cycle while out_ready is high and no batch close or sweep holds
// issue; one row read and one row write of the row memory per cycle; after the final beat
// of every batch the row memory is swept clear; reset is asynchronous active low; it
// restores config defaults and starts the same sweep: beats queue up, then in_ready drops
`default_nettype none

module pixel_moving_sum_trigger_top #(
    parameter int MAX_PAIRS     = 1024,
    parameter int WINDOW_FRAMES = 4,
    parameter int BATCH_FRAMES  = 128
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [pmst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pmst_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // pixel beats in
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [pmst_pkg::PIX_W-1:0]          pixel_low,
    input  wire logic [pmst_pkg::PIX_W-1:0]          pixel_high,
    // result beats out
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     trigger_pulse,
    output logic                                     totals_valid,
    output logic [pmst_pkg::TOT_W-1:0]               total_low,
    output logic [pmst_pkg::TOT_W-1:0]               total_high,
    output logic                                     batch_end
);

    localparam int PAIR_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int SLOT_W  = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
    localparam int FRAME_W = (BATCH_FRAMES > 1) ? $clog2(BATCH_FRAMES) : 1;
    localparam int FLAGS_W = $bits(pmst_pkg::item_flags_t);
    localparam int QDW     = PAIR_W + SLOT_W + FLAGS_W + 2 * pmst_pkg::PIX_W;

    // configuration registers; user writes them only while the block is idle, not enforced
    logic [pmst_pkg::PAIRS_W-1:0] pairs_reg, pairs_next;
    logic [pmst_pkg::THR_W-1:0]   thr_reg, thr_next;

    always_comb
    begin
        pairs_next = pairs_reg;
        thr_next   = thr_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pmst_pkg::REG_PAIRS_IN_USE:
                    pairs_next = cfg_wr_data[pmst_pkg::PAIRS_W-1:0];
                pmst_pkg::REG_WINDOW_THRESHOLD:
                    thr_next = cfg_wr_data[pmst_pkg::THR_W-1:0];
                default:
                begin
                    pairs_next = pairs_reg;
                    thr_next   = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg <= pmst_pkg::PAIRS_RESET;
            thr_reg   <= pmst_pkg::THR_RESET;
        end
        else
        begin
            pairs_reg <= pairs_next;
            thr_reg   <= thr_next;
        end
    end

    // front end: counts pair, window slot and frame, tags each beat
    logic                  q_full, q_push;
    logic [PAIR_W-1:0]     f_pair;
    logic [SLOT_W-1:0]     f_slot;
    pmst_pkg::item_flags_t f_flags;

    pmst_front #(
        .MAX_PAIRS     (MAX_PAIRS),
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .BATCH_FRAMES  (BATCH_FRAMES),
        .PAIR_W        (PAIR_W),
        .SLOT_W        (SLOT_W),
        .FRAME_W       (FRAME_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pairs_in_use (pairs_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .item_pair    (f_pair),
        .item_slot    (f_slot),
        .item_flags   (f_flags)
    );

    // tagged beats wait here so front and back stall independently
    logic [QDW-1:0]                q_wdata, q_rdata;
    logic                          q_valid, q_pop;
    logic [PAIR_W-1:0]             b_pair;
    logic [SLOT_W-1:0]             b_slot;
    pmst_pkg::item_flags_t         b_flags;
    logic [pmst_pkg::PIX_W-1:0]    b_lo, b_hi;

    assign q_wdata = {f_pair, f_slot, f_flags, pixel_high, pixel_low};
    assign {b_pair, b_slot, b_flags, b_hi, b_lo} = q_rdata;

    pmst_queue #(
        .DW (QDW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_valid)
    );

    // back end: row read, window and batch update, trigger, result register
    pmst_back #(
        .MAX_PAIRS     (MAX_PAIRS),
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .PAIR_W        (PAIR_W),
        .SLOT_W        (SLOT_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_pair           (b_pair),
        .q_slot           (b_slot),
        .q_flags          (b_flags),
        .q_lo             (b_lo),
        .q_hi             (b_hi),
        .q_pop            (q_pop),
        .window_threshold (thr_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .trigger_pulse    (trigger_pulse),
        .totals_valid     (totals_valid),
        .total_low        (total_low),
        .total_high       (total_high),
        .batch_end        (batch_end)
    );

endmodule

`default_nettype wire
